// ===== design/bei_pkg.sv =====
// ============================================================================
// bei_pkg
// Shared constants and item types for the breakpoint envelope interpolator.
// ============================================================================
package bei_pkg;

  localparam int NUM_STREAMS    = 64;
  localparam int TIME_BITS      = 24;
  localparam int VALUE_BITS     = 16;
  localparam int STREAM_BITS    = 6;
  localparam int CFG_INDEX_BITS = 1;

  localparam int ADDR_BITS = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
  // quotient bits kept by the divider; anything larger saturates anyway
  localparam int QUO_BITS  = VALUE_BITS + 2;
  localparam int PROD_BITS = TIME_BITS + VALUE_BITS + 2;
  localparam int CNT_BITS  = $clog2(QUO_BITS);

  // item function codes
  localparam logic [1:0] FUNC_RESET  = 2'd0;
  localparam logic [1:0] FUNC_SUPPLY = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_VALID   = 2'd0;
  localparam logic [1:0] ST_NEED    = 2'd1;
  localparam logic [1:0] ST_OUTSIDE = 2'd2;
  localparam logic [1:0] ST_ACK     = 2'd3;

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_FROM = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_TO   = 1'd1;

  typedef struct packed {
    logic [1:0]                   func;
    logic [STREAM_BITS-1:0]       stream;
    logic [TIME_BITS-1:0]         at;
    logic                         point_present;
    logic [TIME_BITS-1:0]         point_at;
    logic signed [VALUE_BITS-1:0] point_val;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic [1:0]                   status;
  } out_item_t;

  // one cursor as stored in the breakpoint memory
  typedef struct packed {
    logic [TIME_BITS-1:0]         left_time;
    logic signed [VALUE_BITS-1:0] left_value;
    logic [TIME_BITS-1:0]         right_time;
    logic signed [VALUE_BITS-1:0] right_value;
  } entry_t;

endpackage

// ===== design/bei_ram.sv =====
// ============================================================================
// bei_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ============================================================================
module bei_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== design/breakpoint_envelope_interpolator.sv =====
// ============================================================================
// breakpoint_envelope_interpolator
// Per-stream piecewise-linear interpolation between supplied breakpoints.
// ============================================================================
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) takes one item: reset all
//   cursors, supply a breakpoint (or end mark) to a stream, or query a stream
//   at a time offset. Every item returns exactly one result item on the
//   output channel (out_valid_o/out_ready_i/out_data_o).
//   Config port (cfg_valid_i/cfg_ready_o), always ready, writes window_from and
//   window_to; write it only while the block idles, which is not enforced.
//   Items other than an interpolating query pass the read and emit states;
//   an interpolating query also passes multiply, divider setup, the radix-2
//   divider (one quotient bit per cycle) and fix-up. A quotient overflow
//   skips the divider and saturates to the largest or smallest value.
//   One item is in flight at a time: the next is accepted once the previous
//   result is loaded into the output register, even if the receiver stalls it.
//   A finished result waits for a free output register before it is loaded.
//   Reset clears every started flag, both window registers and all handshake
//   state; the breakpoint memory is not cleared since its contents are only
//   used for started streams.
// ============================================================================
module breakpoint_envelope_interpolator (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  bei_pkg::in_item_t                      in_data_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output bei_pkg::out_item_t                     out_data_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [bei_pkg::CFG_INDEX_BITS-1:0]     cfg_index_i,
  input  logic [bei_pkg::TIME_BITS-1:0]          cfg_data_i
);
  import bei_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MUL,
    S_DIVSET,
    S_DIV,
    S_FIX,
    S_EMIT
  } state_e;

  localparam int SUM_BITS = QUO_BITS + 2;
  localparam logic signed [SUM_BITS-1:0] SUM_MAX = SUM_BITS'(2 ** (VALUE_BITS - 1) - 1);
  localparam logic signed [SUM_BITS-1:0] SUM_MIN = ~SUM_MAX;
  localparam logic signed [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS - 1){1'b1}}};
  localparam logic signed [VALUE_BITS-1:0] VAL_MIN = ~VAL_MAX;

  state_e                  state_q;
  logic [NUM_STREAMS-1:0]  started_q;
  logic                    out_valid_q;
  out_item_t               out_data_q;
  logic [TIME_BITS-1:0]    win_from_q;
  logic [TIME_BITS-1:0]    win_to_q;

  // datapath registers
  in_item_t                     item_q;
  logic signed [TIME_BITS:0]    dt_q;
  logic signed [TIME_BITS:0]    span_q;
  logic signed [VALUE_BITS:0]   rise_q;
  logic signed [VALUE_BITS-1:0] lv_q;
  logic signed [PROD_BITS-1:0]  prod_q;
  logic [TIME_BITS-1:0]         den_q;
  logic [TIME_BITS-1:0]         rem_q;
  logic [QUO_BITS-1:0]          num_lo_q;
  logic [QUO_BITS-1:0]          quo_q;
  logic                         neg_q;
  logic [CNT_BITS-1:0]          cnt_q;
  logic signed [VALUE_BITS-1:0] res_value_q;
  logic [1:0]                   res_status_q;

  logic                 accept;
  logic                 out_free;
  logic                 ram_we;
  logic [ADDR_BITS-1:0] ram_waddr;
  logic [ADDR_BITS-1:0] ram_raddr;
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t               rd_ent;
  entry_t               wr_ent;
  logic                 in_range;
  logic                 cur_started;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign cfg_ready_o = 1'b1;

  assign ram_raddr   = ADDR_BITS'(in_data_i.stream);
  assign ram_waddr   = ADDR_BITS'(item_q.stream);
  assign rd_ent      = entry_t'(ram_rdata);
  assign in_range    = (32'(item_q.stream) < 32'(NUM_STREAMS));
  assign cur_started = started_q[ram_waddr];
  assign ram_we      = (state_q == S_READ) && (item_q.func == FUNC_SUPPLY) && in_range;

  bei_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(NUM_STREAMS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(wr_ent),
    .re_i   (accept),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Supply: build the updated cursor from the stored one.
  // --------------------------------------------------------------------------
  always_comb begin
    if (!cur_started) begin
      wr_ent.left_time = '0;
      if (item_q.point_present) begin
        wr_ent.left_value  = item_q.point_val;
        wr_ent.right_time  = item_q.point_at;
        wr_ent.right_value = item_q.point_val;
      end else begin
        wr_ent.left_value  = '0;
        wr_ent.right_time  = win_to_q;
        wr_ent.right_value = '0;
      end
    end else begin
      // shift the right point to the left
      wr_ent.left_time  = rd_ent.right_time;
      wr_ent.left_value = rd_ent.right_value;
      if (item_q.point_present) begin
        wr_ent.right_time  = item_q.point_at;
        wr_ent.right_value = item_q.point_val;
      end else begin
        // stream exhausted: hold the value up to the window end
        wr_ent.right_time  = win_to_q;
        wr_ent.right_value = rd_ent.right_value;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Query decode on the freshly read cursor.
  // --------------------------------------------------------------------------
  logic signed [TIME_BITS:0]  span_c;
  logic signed [TIME_BITS:0]  dt_c;
  logic signed [VALUE_BITS:0] rise_c;
  logic                       go_mul;
  logic [1:0]                 rd_status;
  logic signed [VALUE_BITS-1:0] rd_value;

  assign span_c = $signed({1'b0, rd_ent.right_time}) - $signed({1'b0, rd_ent.left_time});
  assign dt_c   = $signed({1'b0, item_q.at}) - $signed({1'b0, rd_ent.left_time});
  assign rise_c = $signed({rd_ent.right_value[VALUE_BITS-1], rd_ent.right_value})
                - $signed({rd_ent.left_value[VALUE_BITS-1], rd_ent.left_value});

  always_comb begin
    go_mul    = 1'b0;
    rd_status = ST_ACK;
    rd_value  = '0;
    case (item_q.func)
      FUNC_QUERY: begin
        if (!in_range) begin
          rd_status = ST_OUTSIDE;
        end else if ((item_q.at < win_from_q) || (item_q.at >= win_to_q)) begin
          rd_status = ST_OUTSIDE;
        end else if (!cur_started || (item_q.at > rd_ent.right_time)) begin
          rd_status = ST_NEED;
        end else if ((span_c == '0) || (rise_c == '0)) begin
          rd_status = ST_VALID;
          rd_value  = rd_ent.left_value;
        end else begin
          rd_status = ST_VALID;
          go_mul    = 1'b1;
        end
      end
      default: begin
        rd_status = ST_ACK;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Divider setup: magnitudes, sign and quotient overflow check.
  // --------------------------------------------------------------------------
  logic [PROD_BITS-1:0]  prod_mag;
  logic signed [TIME_BITS:0] span_abs;
  logic [TIME_BITS-1:0]  span_mag;
  logic                  quo_ovf;

  assign prod_mag = prod_q[PROD_BITS-1] ? PROD_BITS'(-prod_q) : PROD_BITS'(prod_q);
  assign span_abs = span_q[TIME_BITS] ? -span_q : span_q;
  assign span_mag = span_abs[TIME_BITS-1:0];
  assign quo_ovf  = (prod_mag[PROD_BITS-1:QUO_BITS] >= span_mag);

  // one restoring step per cycle
  logic [TIME_BITS:0]   rem_sh;
  logic [TIME_BITS+1:0] trial;
  logic                 qbit;

  assign rem_sh = {rem_q, num_lo_q[QUO_BITS-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, den_q};
  assign qbit   = !trial[TIME_BITS+1];

  // --------------------------------------------------------------------------
  // Final sign, offset by the left value, saturate.
  // --------------------------------------------------------------------------
  logic signed [QUO_BITS:0]   quo_s;
  logic signed [QUO_BITS:0]   quo_signed;
  logic signed [SUM_BITS-1:0] sum_c;
  logic signed [VALUE_BITS-1:0] fix_value;

  assign quo_s      = $signed({1'b0, quo_q});
  assign quo_signed = neg_q ? -quo_s : quo_s;
  assign sum_c      = $signed({quo_signed[QUO_BITS], quo_signed})
                    + $signed({{(SUM_BITS - VALUE_BITS){lv_q[VALUE_BITS-1]}}, lv_q});

  always_comb begin
    if (sum_c > SUM_MAX) begin
      fix_value = VAL_MAX;
    end else if (sum_c < SUM_MIN) begin
      fix_value = VAL_MIN;
    end else begin
      fix_value = sum_c[VALUE_BITS-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Configuration registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_from_q <= '0;
      win_to_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_WINDOW_FROM: win_from_q <= cfg_data_i;
        CFG_WINDOW_TO:   win_to_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: state, started flags and the output register.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      started_q   <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      // drop a taken result unless a new one is loaded at this edge
      if (out_valid_q && out_ready_i && (state_q != S_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_READ;
          end
        end
        S_READ: begin
          if (item_q.func == FUNC_RESET) begin
            started_q <= '0;
          end
          if (ram_we) begin
            started_q[ram_waddr] <= 1'b1;
          end
          state_q <= go_mul ? S_MUL : S_EMIT;
        end
        S_MUL: begin
          state_q <= S_DIVSET;
        end
        S_DIVSET: begin
          state_q <= quo_ovf ? S_EMIT : S_DIV;
        end
        S_DIV: begin
          if (cnt_q == '0) begin
            state_q <= S_FIX;
          end
        end
        S_FIX: begin
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          // hold the result until the output register frees up
          if (out_free) begin
            out_valid_q       <= 1'b1;
            out_data_q.value  <= res_value_q;
            out_data_q.status <= res_status_q;
            state_q           <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
    case (state_q)
      S_READ: begin
        res_status_q <= rd_status;
        res_value_q  <= rd_value;
        dt_q         <= dt_c;
        span_q       <= span_c;
        rise_q       <= rise_c;
        lv_q         <= rd_ent.left_value;
      end
      S_MUL: begin
        prod_q <= dt_q * rise_q;
      end
      S_DIVSET: begin
        neg_q    <= prod_q[PROD_BITS-1] ^ span_q[TIME_BITS];
        den_q    <= span_mag;
        rem_q    <= prod_mag[PROD_BITS-1:QUO_BITS];
        num_lo_q <= prod_mag[QUO_BITS-1:0];
        quo_q    <= '0;
        cnt_q    <= CNT_BITS'(QUO_BITS - 1);
        if (quo_ovf) begin
          // quotient too large for any in-range result
          res_value_q <= (prod_q[PROD_BITS-1] ^ span_q[TIME_BITS]) ? VAL_MIN : VAL_MAX;
        end
      end
      S_DIV: begin
        rem_q    <= qbit ? trial[TIME_BITS-1:0] : rem_sh[TIME_BITS-1:0];
        quo_q    <= {quo_q[QUO_BITS-2:0], qbit};
        num_lo_q <= {num_lo_q[QUO_BITS-2:0], 1'b0};
        cnt_q    <= cnt_q - 1'b1;
      end
      S_FIX: begin
        res_value_q <= fix_value;
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < den_q))
    else $error("divider remainder not below divisor");

  a_supply_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> started_q[$past(ram_waddr)])
    else $error("supplied stream not marked started");

  a_status_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status != ST_VALID)) |-> (out_data_o.value == '0))
    else $error("non-valid status carries a nonzero value");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("second item accepted while one is in flight");

endmodule
